// ----- rtl/core/bounded_deque_with_search_top_defines.svh -----
// Assertion macros used by the deque RTL.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDQS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bdqs: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BDQS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bdqs: next-cycle check failed");

`endif

// ----- rtl/core/bdqs_pkg.sv -----
// Package with the sizes, request codes and status codes of the deque.
`default_nettype none

package bdqs_pkg;

  // Store depth; must be a power of two so that slot arithmetic wraps.
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 32;
  localparam int REQ_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_HEAD   = 3'd0,
    REQ_INS_TAIL   = 3'd1,
    REQ_DEL_HEAD   = 3'd2,
    REQ_DEL_TAIL   = 3'd3,
    REQ_FIND       = 3'd4,
    REQ_REMOVE_ALL = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/bounded_deque_with_search_top.sv -----
// Bounded double-ended queue of signed keys with find and remove-all.
//
// Usage: each request item enters on the in_ stream (in_tuser = request
// code, in_tdata = key) and gives exactly one result item on the out_
// stream (out_tdata = removed key or found position, out_tuser = status).
// The block works on one item at a time; in_tready is high only while the
// sequencer is idle. For inserts, clear and unused codes the result goes
// from S_EXEC to S_DONE and into the output register; deletes pass through
// S_DELW in between for one registered read of the key store. Find and
// remove-all walk the live entries through the single store read port, one
// entry per cycle; a find stops at its first hit. The next item can be
// taken in the cycle after the result is loaded into the output register.
// A finished result waits in the sequencer while out_tvalid is high and
// out_tready is low, and the block stays busy until it can be loaded.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; the key store itself is not cleared and needs no sweep.
`default_nettype none

`include "bounded_deque_with_search_top_defines.svh"

module bounded_deque_with_search_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [bdqs_pkg::KEY_W-1:0]   in_tdata,   // [31:0] key_in
  input  logic        [bdqs_pkg::REQ_W-1:0]   in_tuser,   // [2:0] req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic signed [bdqs_pkg::KEY_W-1:0]   out_tdata,  // [31:0] data_out
  output logic        [bdqs_pkg::STAT_W-1:0]  out_tuser   // [1:0] status
);
  import bdqs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DELW = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  // Sequencer and queue state.
  state_t                   st_r, st_nxt;
  req_t                     req_r, req_nxt;
  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]         front_r, front_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;

  // Scan counters: read position, write position and the compare stage.
  logic [CNT_W-1:0]         rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0]         wr_i_r, wr_i_nxt;
  logic                     cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0]         cmp_i_r, cmp_i_nxt;

  // Result held by the sequencer and the output register.
  logic signed [KEY_W-1:0]  res_data_r, res_data_nxt;
  status_t                  res_status_r, res_status_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0]  out_data_r, out_data_nxt;
  status_t                  out_status_r, out_status_nxt;

  // Key store with one write port and one registered read port.
  logic signed [KEY_W-1:0]  mem [DEPTH];
  logic signed [KEY_W-1:0]  rd_data_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic [IDX_W-1:0]         mem_ra;
  logic signed [KEY_W-1:0]  mem_wd;

  logic                     full;
  logic                     empty;
  logic                     issue;
  logic                     hit;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign issue = (rd_i_r != count_r);
  assign hit   = cmp_v_r && (rd_data_r == key_r);

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Sequencer next-state logic.
  always_comb begin
    st_nxt         = st_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    rd_i_nxt       = rd_i_r;
    wr_i_nxt       = wr_i_r;
    cmp_v_nxt      = cmp_v_r;
    cmp_i_nxt      = cmp_i_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = front_r;
    mem_wd         = key_r;
    mem_ra         = front_r;

    // The receiver took the current result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt = req_t'(in_tuser);
          key_nxt = in_tdata;
          st_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        res_data_nxt   = '0;
        res_status_nxt = ST_OK;
        rd_i_nxt       = '0;
        wr_i_nxt       = '0;
        cmp_v_nxt      = 1'b0;
        st_nxt         = S_DONE;
        unique case (req_r)
          REQ_INS_HEAD: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              front_nxt = front_r - IDX_W'(1);
              mem_we    = 1'b1;
              mem_wa    = front_r - IDX_W'(1);
              count_nxt = count_r + CNT_W'(1);
            end
          end
          REQ_INS_TAIL: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_wa    = front_r + count_r[IDX_W-1:0];
              count_nxt = count_r + CNT_W'(1);
            end
          end
          REQ_DEL_HEAD: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_ra = front_r;
              st_nxt = S_DELW;
            end
          end
          REQ_DEL_TAIL: begin
            if (empty) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              mem_ra = front_r + IDX_W'(count_r - CNT_W'(1));
              st_nxt = S_DELW;
            end
          end
          REQ_FIND: begin
            res_status_nxt = ST_NOT_FOUND;
            st_nxt         = S_SCAN;
          end
          REQ_REMOVE_ALL: begin
            st_nxt = S_SCAN;
          end
          REQ_CLEAR: begin
            front_nxt = '0;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      // The removed key arrives from the read port.
      S_DELW: begin
        res_data_nxt = rd_data_r;
        count_nxt    = count_r - CNT_W'(1);
        if (req_r == REQ_DEL_HEAD) begin
          front_nxt = front_r + IDX_W'(1);
        end
        st_nxt = S_DONE;
      end

      // One entry is read while entries remain and the previous one is compared in every cycle.
      S_SCAN: begin
        mem_ra    = front_r + rd_i_r[IDX_W-1:0];
        cmp_v_nxt = issue;
        cmp_i_nxt = rd_i_r[IDX_W-1:0];
        if (issue) begin
          rd_i_nxt = rd_i_r + CNT_W'(1);
        end
        priority if (req_r == REQ_FIND && hit) begin
          res_data_nxt   = KEY_W'(cmp_i_r);
          res_status_nxt = ST_OK;
          st_nxt         = S_DONE;
        end else if (!issue && !cmp_v_r) begin
          if (req_r == REQ_REMOVE_ALL) begin
            count_nxt = wr_i_r;
          end
          st_nxt = S_DONE;
        end else if (req_r == REQ_REMOVE_ALL && cmp_v_r && !hit) begin
          // Compact the kept keys toward the head.
          mem_we   = 1'b1;
          mem_wa   = front_r + wr_i_r[IDX_W-1:0];
          mem_wd   = rd_data_r;
          wr_i_nxt = wr_i_r + CNT_W'(1);
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          st_nxt         = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    rd_i_r       <= rd_i_nxt;
    wr_i_r       <= wr_i_nxt;
    cmp_i_r      <= cmp_i_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  // Key store access.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  // Checks on the sequencer and the queue state.
  `BDQS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `BDQS_ASSERT_IMP(a_scan_order, st_r == S_SCAN, wr_i_r <= rd_i_r)
  `BDQS_ASSERT_NXT(a_accept_exec, in_tvalid && in_tready, st_r == S_EXEC)
  `BDQS_ASSERT_NXT(a_done_loads, st_r == S_DONE && (!out_tvalid || out_tready), out_tvalid)

endmodule

`default_nettype wire
